// File: design/i2r_pkg.sv
`default_nettype none

package i2r_pkg;

  // numeral table size and index width
  localparam int unsigned Entries = 13;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned ValW    = 12;
  localparam int unsigned WgtW    = 10;
  localparam int unsigned SymW    = 7;

  localparam logic [ValW-1:0] MaxValue = 12'd3999;

  // ascii codes of the roman characters
  localparam logic [SymW-1:0] ChM = 7'h4D;
  localparam logic [SymW-1:0] ChD = 7'h44;
  localparam logic [SymW-1:0] ChC = 7'h43;
  localparam logic [SymW-1:0] ChL = 7'h4C;
  localparam logic [SymW-1:0] ChX = 7'h58;
  localparam logic [SymW-1:0] ChV = 7'h56;
  localparam logic [SymW-1:0] ChI = 7'h49;
  localparam logic [SymW-1:0] ChNone = 7'h00;

  typedef struct packed {
    logic [WgtW-1:0] weight;
    logic            pair;
    logic [SymW-1:0] ch0;
    logic [SymW-1:0] ch1;
  } entry_t;

  // result of the shared compare and subtract unit
  typedef struct packed {
    logic            ge;
    logic [ValW-1:0] diff;
  } cmpsub_t;

  // greedy descending table, subtractive pairs included
  function automatic entry_t entry_at(input logic [IdxW-1:0] idx);
    entry_t e;
    unique case (idx)
      4'd0:    e = '{weight: 10'd1000, pair: 1'b0, ch0: ChM, ch1: ChNone};
      4'd1:    e = '{weight: 10'd900,  pair: 1'b1, ch0: ChC, ch1: ChM};
      4'd2:    e = '{weight: 10'd500,  pair: 1'b0, ch0: ChD, ch1: ChNone};
      4'd3:    e = '{weight: 10'd400,  pair: 1'b1, ch0: ChC, ch1: ChD};
      4'd4:    e = '{weight: 10'd100,  pair: 1'b0, ch0: ChC, ch1: ChNone};
      4'd5:    e = '{weight: 10'd90,   pair: 1'b1, ch0: ChX, ch1: ChC};
      4'd6:    e = '{weight: 10'd50,   pair: 1'b0, ch0: ChL, ch1: ChNone};
      4'd7:    e = '{weight: 10'd40,   pair: 1'b1, ch0: ChX, ch1: ChL};
      4'd8:    e = '{weight: 10'd10,   pair: 1'b0, ch0: ChX, ch1: ChNone};
      4'd9:    e = '{weight: 10'd9,    pair: 1'b1, ch0: ChI, ch1: ChX};
      4'd10:   e = '{weight: 10'd5,    pair: 1'b0, ch0: ChV, ch1: ChNone};
      4'd11:   e = '{weight: 10'd4,    pair: 1'b1, ch0: ChI, ch1: ChV};
      default: e = '{weight: 10'd1,    pair: 1'b0, ch0: ChI, ch1: ChNone};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: design/i2r_if.sv
`default_nettype none

// input word channel
interface i2r_in_if;
  import i2r_pkg::*;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// output word channel, one character per word
interface i2r_out_if;
  import i2r_pkg::*;
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;
  logic            error;

  modport source (output valid, output symbol, output last, output error, input ready);
  modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

`default_nettype wire

// File: design/i2r_cmpsub.sv
`default_nettype none

module i2r_cmpsub import i2r_pkg::*; (
  input  logic [ValW-1:0] rem_i,
  input  logic [WgtW-1:0] weight_i,
  output cmpsub_t         res_o
);

  logic [ValW:0] diff;

  // one subtract gives both the compare and the new remainder
  assign diff       = {1'b0, rem_i} - {{(ValW+1-WgtW){1'b0}}, weight_i};
  assign res_o.ge   = ~diff[ValW];
  assign res_o.diff = diff[ValW-1:0];

endmodule

`default_nettype wire

// File: design/integer_to_roman_numeral_top.sv
`default_nettype none

// channel | dir | words                | payload
// in_i    | in  | one value per word   | value[11:0]
// out_o   | out | one char per word    | symbol[6:0], last, error
//
// a value is taken from idle, then the sequencer walks the table in descending order,
// skipping entries above the remainder and issuing characters; no new value is taken
// until the last character is issued; a single shared compare/subtract unit serves all steps
// out-of-range values (0 or above 3999) give one error word the cycle after they are taken
// reset clears the sequencer and the output register; no state spans items
// a stalled output word holds and the sequencer waits until it is taken

module integer_to_roman_numeral_top import i2r_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i2r_in_if.sink     in_i,
  i2r_out_if.source  out_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e          state_q, state_d;
  logic [ValW-1:0] rem_q, rem_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  logic [SymW-1:0] sym_q, sym_d;
  logic            last_q, last_d;
  logic            err_q, err_d;

  entry_t  cur;
  cmpsub_t cs;
  logic    out_free;
  logic    in_fire;
  logic    bad_value;

  assign cur = entry_at(idx_q);

  // shared compare/subtract unit
  i2r_cmpsub u_cmpsub (
    .rem_i    (rem_q),
    .weight_i (cur.weight),
    .res_o    (cs)
  );

  assign out_free  = ~out_valid_q | out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) & out_free;
  assign in_fire   = in_i.valid & in_i.ready;
  assign bad_value = (in_i.value == '0) || (in_i.value > MaxValue);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    sym_d       = sym_q;
    last_d      = last_q;
    err_d       = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (bad_value) begin
            out_valid_d = 1'b1;
            sym_d       = ChNone;
            last_d      = 1'b1;
            err_d       = 1'b1;
          end else begin
            rem_d   = in_i.value;
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          if (pend_q) begin
            // second character of a subtractive pair
            out_valid_d = 1'b1;
            sym_d       = cur.ch1;
            last_d      = (rem_q == '0);
            err_d       = 1'b0;
            pend_d      = 1'b0;
            if (rem_q == '0) begin
              state_d = ST_IDLE;
            end
          end else if (cs.ge) begin
            out_valid_d = 1'b1;
            sym_d       = cur.ch0;
            err_d       = 1'b0;
            rem_d       = cs.diff;
            if (cur.pair) begin
              pend_d = 1'b1;
              last_d = 1'b0;
            end else begin
              last_d = (cs.diff == '0);
              if (cs.diff == '0) begin
                state_d = ST_IDLE;
              end
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sym_q       <= '0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      sym_q       <= sym_d;
      last_q      <= last_d;
      err_q       <= err_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = sym_q;
  assign out_o.last   = last_q;
  assign out_o.error  = err_q;

endmodule

`default_nettype wire

// File: sim/tb_integer_to_roman_numeral_top.sv
`default_nettype none

module tb_integer_to_roman_numeral_top import i2r_pkg::*; ();

  // one expected output word
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            error;
  } numeral_word_t;

  // a numeral as packed ascii, first character in the upper bytes, zero on error
  localparam int unsigned TextW = 15 * 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  i2r_in_if  in_ch ();
  i2r_out_if out_ch ();

  numeral_word_t numeral_q [$];
  int            fail_count = 0;
  bit            quiet = 1'b0;

  integer_to_roman_numeral_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // roman text of a value, built one decimal digit at a time
  function automatic logic [TextW-1:0] roman_text(input logic [ValW-1:0] v);
    logic [TextW-1:0] txt;
    int unsigned      rem;
    int unsigned      dig;
    logic [SymW-1:0]  one;
    logic [SymW-1:0]  five;
    logic [SymW-1:0]  ten;
    txt = '0;
    if (v == '0 || v > MaxValue) return txt;
    rem = 32'(v);
    repeat (rem / 1000) txt = {txt[TextW-9:0], 1'b0, ChM};
    rem = rem % 1000;
    for (int p = 100; p >= 1; p = p / 10) begin
      dig = rem / p;
      rem = rem % p;
      case (p)
        100: begin
          one = ChC; five = ChD; ten = ChM;
        end
        10: begin
          one = ChX; five = ChL; ten = ChC;
        end
        default: begin
          one = ChI; five = ChV; ten = ChX;
        end
      endcase
      // subtractive pairs for nine and four
      if (dig == 9) begin
        txt = {txt[TextW-17:0], 1'b0, one, 1'b0, ten};
      end else if (dig == 4) begin
        txt = {txt[TextW-17:0], 1'b0, one, 1'b0, five};
      end else begin
        if (dig >= 5) txt = {txt[TextW-9:0], 1'b0, five};
        repeat (dig % 5) txt = {txt[TextW-9:0], 1'b0, one};
      end
    end
    return txt;
  endfunction

  // expected words for one numeral; empty text stands for the error word
  function automatic void queue_numeral(input logic [TextW-1:0] txt);
    numeral_word_t w;
    if (txt == '0) begin
      numeral_q.push_back({ChNone, 1'b1, 1'b1});
      return;
    end
    for (int k = 14; k >= 0; k--) begin
      if (txt[k*8 +: 8] != 8'd0) begin
        w.symbol = txt[k*8 +: SymW];
        w.last   = (k == 0);
        w.error  = 1'b0;
        numeral_q.push_back(w);
      end
    end
  endfunction

  // directed values; typed rows carry the numeral written out by hand
  task automatic directed_row(input int i, output logic [ValW-1:0] v, output bit typed,
                              output logic [TextW-1:0] txt);
    typed = 1'b1;
    txt   = '0;
    case (i)
      0:  v = 12'd0;
      1:  v = 12'd4000;
      2:  v = 12'd4095;
      3:  begin v = 12'd3999; txt = "MMMCMXCIX";       end
      4:  begin v = 12'd1;    txt = "I";               end
      5:  begin v = 12'd3888; txt = "MMMDCCCLXXXVIII"; end
      6:  begin v = 12'd4;    txt = "IV";              end
      7:  begin v = 12'd9;    txt = "IX";              end
      8:  begin v = 12'd40;   txt = "XL";              end
      9:  begin v = 12'd90;   txt = "XC";              end
      10: begin v = 12'd400;  txt = "CD";              end
      11: begin v = 12'd900;  txt = "CM";              end
      12: begin v = 12'd5;    txt = "V";               end
      13: begin v = 12'd50;   txt = "L";               end
      14: begin v = 12'd500;  txt = "D";               end
      15: begin v = 12'd1000; txt = "M";               end
      16: begin v = 12'd2048; typed = 1'b0; end
      17: begin v = 12'd1365; typed = 1'b0; end
      18: begin v = 12'd2730; typed = 1'b0; end
      19: begin v = 12'd444;  typed = 1'b0; end
      20: begin v = 12'd1994; typed = 1'b0; end
      21: begin v = 12'd3;    typed = 1'b0; end
      22: begin v = 12'd49;   typed = 1'b0; end
      default: begin v = 12'd4001; typed = 1'b0; end
    endcase
  endtask

  // offer one value and hold it until taken; valid stays high for the next word
  task automatic send_value(input logic [ValW-1:0] v);
    if (!quiet && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // output side: random stalls and word checks
  always @(posedge clk) begin
    numeral_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (numeral_q.size() == 0) begin
        $display("%0t: unexpected word symbol=%h last=%b error=%b", $time,
                 out_ch.symbol, out_ch.last, out_ch.error);
        fail_count++;
      end else begin
        exp_w = numeral_q.pop_front();
        if (out_ch.symbol !== exp_w.symbol) begin
          $display("%0t: symbol expected %h actual %h", $time, exp_w.symbol, out_ch.symbol);
          fail_count++;
        end
        if (out_ch.last !== exp_w.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_w.last, out_ch.last);
          fail_count++;
        end
        if (out_ch.error !== exp_w.error) begin
          $display("%0t: error expected %b actual %b", $time, exp_w.error, out_ch.error);
          fail_count++;
        end
      end
    end
    out_ch.ready <= quiet || ($urandom_range(99) >= 6);
  end

  // stimulus
  initial begin
    logic [ValW-1:0]  v;
    logic [TextW-1:0] txt;
    bit               typed;
    int unsigned      sel;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < 24; i++) begin
      directed_row(i, v, typed, txt);
      send_value(v);
      queue_numeral(typed ? txt : roman_text(v));
    end

    // hold off until every numeral has drained
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (numeral_q.size() != 0);

    // random values, mostly in range
    for (int i = 0; i < 126; i++) begin
      quiet = (i >= 40 && i < 80);
      sel = $urandom_range(99);
      if (sel < 60)      v = ValW'($urandom_range(1, 3999));
      else if (sel < 75) v = ValW'($urandom_range(1, 60));
      else if (sel < 85) v = ValW'($urandom_range(4000, 4095));
      else if (sel < 90) v = '0;
      else               v = ValW'($urandom);
      send_value(v);
      queue_numeral(roman_text(v));
    end
    in_ch.valid <= 1'b0;
    quiet = 1'b0;

    // drain and give the block time for stray words
    while (numeral_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_integer_to_roman_numeral_top passed");
    end else begin
      $display("tb_integer_to_roman_numeral_top failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_integer_to_roman_numeral_top failed");
    $finish;
  end

endmodule

`default_nettype wire
